// ===== rtl/hdma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdma_pkg: shared types and constants
// Phase codes, bus operation codes, command codes, register indexes, result record.
// ----------------------------------------------------------------------------
package hdma_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DMA_READ  = 3'd1,
    PH_HDR       = 3'd2,
    PH_HDR_HI    = 3'd3,
    PH_IND_LO    = 3'd4,
    PH_IND_HI    = 3'd5,
    PH_IND_BANK  = 3'd6,
    PH_HDMA_DATA = 3'd7
  } phase_t;

  localparam logic [2:0] OP_DONE    = 3'd0;
  localparam logic [2:0] OP_READ_A  = 3'd1;
  localparam logic [2:0] OP_WRITE_A = 3'd2;
  localparam logic [2:0] OP_READ_B  = 3'd3;
  localparam logic [2:0] OP_WRITE_B = 3'd4;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;
  localparam logic [1:0] CMD_DATA  = 2'd3;

  localparam logic [2:0] REG_PARAMS   = 3'd0;
  localparam logic [2:0] REG_B_ADDR   = 3'd1;
  localparam logic [2:0] REG_A_ADDR   = 3'd2;
  localparam logic [2:0] REG_A_BANK   = 3'd3;
  localparam logic [2:0] REG_COUNT    = 3'd4;
  localparam logic [2:0] REG_IND_BANK = 3'd5;
  localparam logic [2:0] REG_HDMA_EN  = 3'd6;

  typedef struct packed {
    logic [2:0]  bus_op;
    logic [23:0] address;
    logic [7:0]  data;
    logic [19:0] master_clocks;
    logic        last;
  } result_t;

endpackage

// ===== rtl/dma_hdma_channel_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_hdma_channel_controller_core: one DMA / HDMA channel
// Turns commands and returned read data into a stream of bus requests.
// ----------------------------------------------------------------------------
// Usage:
//  in_* carries commands (start DMA, frame start, HDMA line, read data).
//  out_* carries bus requests and done markers, one per transfer.
//  cfg_* writes channel registers; user keeps to an idle channel, unchecked.
//  An accepted command is registered together with its results (0 to 2); they
//  join a three-entry output buffer behind any pending result and leave one per
//  cycle while out_stall is low. A command producing one result sustains one
//  item per cycle while out_stall is low; one producing two raises in_stall
//  until only one result is pending, as the single output port drains it.
//  in_stall is raised while the buffer holds more than one pending result,
//  so a stalled receiver back-pressures the input without losing data.
//  Reset clears config, state and buffer count, phase idle; entries are kept.
// ----------------------------------------------------------------------------
module dma_hdma_channel_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_bus_op,
  output logic [23:0] out_address,
  output logic [7:0]  out_data,
  output logic [19:0] out_master_clocks,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // config
  logic [7:0]  params_r, b_addr_r, a_bank_r, ind_bank_r;
  logic [15:0] a_addr_r, count_r;
  logic        hdma_en_r;

  // state
  hdma_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] work_r, work_nxt;
  logic [16:0] left_r, left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [19:0] clk_r, clk_nxt;
  logic [14:0] lines_r, lines_nxt;
  logic rep_r, rep_nxt, xfer_r, xfer_nxt, fin_r, fin_nxt, ptr_r, ptr_nxt;
  logic [15:0] ind_r, ind_nxt;
  logic [7:0]  ibank_r, ibank_nxt, latch_r, latch_nxt;

  // output buffer: three entries, so a two-result transfer fits behind one
  hdma_pkg::result_t buf_r [3];
  hdma_pkg::result_t buf_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;

  hdma_pkg::result_t r0, r1;
  logic [1:0] nres;

  logic in_fire, out_fire;
  assign in_stall  = (cnt_r > 2'd1);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;

  logic [2:0] unit;
  always_comb begin
    case (params_r[2:0])
      3'd1, 3'd2: unit = 3'd2;
      3'd3, 3'd4: unit = 3'd4;
      default:    unit = 3'd1;
    endcase
  end

  function automatic hdma_pkg::result_t mk(input logic [2:0] op, input logic [23:0] a,
                                           input logic [7:0] d, input logic [19:0] c,
                                           input logic l);
    hdma_pkg::result_t r;
    r.bus_op = op; r.address = a; r.data = d; r.master_clocks = c; r.last = l;
    return r;
  endfunction

  logic [15:0] hdr;
  logic [7:0]  btgt;
  logic [2:0]  posp1;
  logic [15:0] wstep;
  assign btgt  = b_addr_r + {6'd0, pos_r};
  assign posp1 = {1'b0, pos_r} + 3'd1;
  assign wstep = params_r[4] ? work_r : (params_r[3] ? work_r - 16'd1 : work_r + 16'd1);

  always_comb begin
    logic [15:0] lines;
    logic        rep;
    logic        do_hdr;
    logic        do_begin;
    logic        do_data;
    logic [15:0] w;
    logic [16:0] bl;
    logic [19:0] ct;
    lines = 16'd0; rep = 1'b0; do_hdr = 1'b0; do_begin = 1'b0; do_data = 1'b0;
    w = work_r; bl = left_r; ct = clk_r;
    phase_nxt = phase_r; work_nxt = work_r; left_nxt = left_r; pos_nxt = pos_r;
    clk_nxt = clk_r; lines_nxt = lines_r; rep_nxt = rep_r; xfer_nxt = xfer_r;
    fin_nxt = fin_r; ptr_nxt = ptr_r; ind_nxt = ind_r; ibank_nxt = ibank_r;
    latch_nxt = latch_r;
    r0 = '0; r1 = '0; nres = 2'd0;
    hdr = {in_read_data, latch_r};
    case (in_command)
      hdma_pkg::CMD_FRAME: begin
        work_nxt = a_addr_r; fin_nxt = 1'b0; lines_nxt = '0; rep_nxt = 1'b0;
        xfer_nxt = 1'b0; ptr_nxt = 1'b0; ind_nxt = '0; ibank_nxt = ind_bank_r;
        pos_nxt = '0; left_nxt = '0; phase_nxt = hdma_pkg::PH_IDLE;
      end
      hdma_pkg::CMD_START: begin
        if (phase_r == hdma_pkg::PH_IDLE) begin
          left_nxt = (count_r == 16'd0) ? 17'h10000 : {1'b0, count_r};
          clk_nxt = '0; pos_nxt = '0; nres = 2'd1;
          phase_nxt = hdma_pkg::PH_DMA_READ;
          if (!params_r[7]) begin
            r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
            work_nxt = wstep;
          end else begin
            r0 = mk(hdma_pkg::OP_READ_B, {16'd0, b_addr_r}, 8'd0, 20'd0, 1'b0);
          end
        end
      end
      hdma_pkg::CMD_LINE: begin
        if (phase_r == hdma_pkg::PH_IDLE) begin
          nres = 2'd1;
          if (!hdma_en_r || fin_r) begin
            r0 = mk(hdma_pkg::OP_DONE, 24'd0, 8'd0, 20'd0, 1'b1);
          end else if (lines_r == 15'd0) begin
            r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
            work_nxt = work_r + 16'd1;
            phase_nxt = hdma_pkg::PH_HDR;
          end else begin
            xfer_nxt = rep_r;
            lines_nxt = lines_r - 15'd1;
            if (!rep_r) r0 = mk(hdma_pkg::OP_DONE, 24'd0, 8'd0, 20'd0, 1'b1);
            else do_begin = 1'b1;
          end
        end
      end
      default: begin
        unique case (phase_r)
          hdma_pkg::PH_DMA_READ: begin
            nres = 2'd2;
            if (!params_r[7]) begin
              r0 = mk(hdma_pkg::OP_WRITE_B, {16'd0, btgt}, in_read_data, 20'd0, 1'b0);
            end else begin
              r0 = mk(hdma_pkg::OP_WRITE_A, {a_bank_r, work_r}, in_read_data, 20'd0, 1'b0);
              w = wstep;
            end
            ct = clk_r + 20'd8;
            bl = left_r - 17'd1;
            clk_nxt = ct; left_nxt = bl;
            pos_nxt = (posp1 >= unit) ? 2'd0 : posp1[1:0];
            if (bl == 17'd0) begin
              r1 = mk(hdma_pkg::OP_DONE, 24'd0, 8'd0, ct, 1'b1);
              phase_nxt = hdma_pkg::PH_IDLE;
              work_nxt = w;
            end else if (!params_r[7]) begin
              r1 = mk(hdma_pkg::OP_READ_A, {a_bank_r, w}, 8'd0, 20'd0, 1'b0);
              work_nxt = params_r[4] ? w : (params_r[3] ? w - 16'd1 : w + 16'd1);
            end else begin
              r1 = mk(hdma_pkg::OP_READ_B, {16'd0, b_addr_r + {6'd0, pos_nxt}},
                      8'd0, 20'd0, 1'b0);
              work_nxt = w;
            end
          end
          hdma_pkg::PH_HDR: begin
            nres = 2'd1;
            if (unit == 3'd1) begin
              do_hdr = 1'b1; lines = {9'd0, in_read_data[6:0]}; rep = in_read_data[7];
            end else begin
              latch_nxt = in_read_data;
              r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
              work_nxt = work_r + 16'd1;
              phase_nxt = hdma_pkg::PH_HDR_HI;
            end
          end
          hdma_pkg::PH_HDR_HI: begin
            nres = 2'd1; do_hdr = 1'b1; lines = {1'b0, hdr[14:0]}; rep = hdr[15];
          end
          hdma_pkg::PH_IND_LO: begin
            nres = 2'd1; latch_nxt = in_read_data;
            r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
            work_nxt = work_r + 16'd1;
            phase_nxt = hdma_pkg::PH_IND_HI;
          end
          hdma_pkg::PH_IND_HI: begin
            nres = 2'd1;
            ind_nxt = hdr; ibank_nxt = ind_bank_r;
            if (unit == 3'd4) begin
              r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
              work_nxt = work_r + 16'd1;
              phase_nxt = hdma_pkg::PH_IND_BANK;
            end else begin
              ptr_nxt = 1'b1;
              r0 = mk(hdma_pkg::OP_READ_A, {ind_bank_r, hdr}, 8'd0, 20'd0, 1'b0);
              ind_nxt = hdr + 16'd1;
              phase_nxt = hdma_pkg::PH_HDMA_DATA;
            end
          end
          hdma_pkg::PH_IND_BANK: begin
            nres = 2'd1; ibank_nxt = in_read_data; ptr_nxt = 1'b1;
            r0 = mk(hdma_pkg::OP_READ_A, {in_read_data, ind_r}, 8'd0, 20'd0, 1'b0);
            ind_nxt = ind_r + 16'd1;
            phase_nxt = hdma_pkg::PH_HDMA_DATA;
          end
          hdma_pkg::PH_HDMA_DATA: begin
            if (posp1 >= unit) begin
              nres = 2'd1; pos_nxt = '0;
              r0 = mk(hdma_pkg::OP_WRITE_B, {16'd0, btgt}, in_read_data, 20'd0, 1'b1);
              phase_nxt = hdma_pkg::PH_IDLE;
            end else begin
              nres = 2'd2; pos_nxt = posp1[1:0];
              r0 = mk(hdma_pkg::OP_WRITE_B, {16'd0, btgt}, in_read_data, 20'd0, 1'b0);
              do_data = 1'b1;
            end
          end
          default: ;
        endcase
      end
    endcase

    if (do_hdr) begin
      rep_nxt = rep;
      if (lines == 16'd0) begin
        fin_nxt = 1'b1;
        r0 = mk(hdma_pkg::OP_DONE, 24'd0, 8'd0, 20'd0, 1'b1);
        phase_nxt = hdma_pkg::PH_IDLE;
      end else begin
        lines_nxt = lines[14:0] - 15'd1;
        xfer_nxt = 1'b1;
        ptr_nxt = 1'b0;
        do_begin = 1'b1;
      end
    end
    if (do_begin) begin
      pos_nxt = '0;
      if (params_r[6] && !(ptr_r && !do_hdr)) begin
        r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
        work_nxt = work_r + 16'd1;
        phase_nxt = hdma_pkg::PH_IND_LO;
      end else if (params_r[6]) begin
        r0 = mk(hdma_pkg::OP_READ_A, {ibank_r, ind_r}, 8'd0, 20'd0, 1'b0);
        ind_nxt = ind_r + 16'd1;
        phase_nxt = hdma_pkg::PH_HDMA_DATA;
      end else begin
        r0 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
        work_nxt = work_r + 16'd1;
        phase_nxt = hdma_pkg::PH_HDMA_DATA;
      end
    end
    if (do_data) begin
      if (params_r[6]) begin
        r1 = mk(hdma_pkg::OP_READ_A, {ibank_r, ind_r}, 8'd0, 20'd0, 1'b0);
        ind_nxt = ind_r + 16'd1;
      end else begin
        r1 = mk(hdma_pkg::OP_READ_A, {a_bank_r, work_r}, 8'd0, 20'd0, 1'b0);
        work_nxt = work_r + 16'd1;
      end
      phase_nxt = hdma_pkg::PH_HDMA_DATA;
    end
  end

  // output buffer update; input is taken only with at most one entry held
  always_comb begin
    logic [1:0] c;
    buf_nxt[0] = buf_r[0];
    buf_nxt[1] = buf_r[1];
    buf_nxt[2] = buf_r[2];
    c = cnt_r;
    if (out_fire) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      c = cnt_r - 2'd1;
    end
    if (in_fire && nres != 2'd0) begin
      if (c == 2'd0) begin
        buf_nxt[0] = r0;
        buf_nxt[1] = r1;
      end else begin
        buf_nxt[1] = r0;
        buf_nxt[2] = r1;
      end
    end
    cnt_nxt = in_fire ? c + nres : c;
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      params_r <= '0; b_addr_r <= '0; a_addr_r <= '0; a_bank_r <= '0;
      count_r <= '0; ind_bank_r <= '0; hdma_en_r <= 1'b0;
      phase_r <= hdma_pkg::PH_IDLE; work_r <= '0; left_r <= '0; pos_r <= '0;
      clk_r <= '0; lines_r <= '0; rep_r <= 1'b0; xfer_r <= 1'b0; fin_r <= 1'b0;
      ptr_r <= 1'b0; ind_r <= '0; ibank_r <= '0; latch_r <= '0; cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt; work_r <= work_nxt; left_r <= left_nxt;
        pos_r <= pos_nxt; clk_r <= clk_nxt; lines_r <= lines_nxt; rep_r <= rep_nxt;
        xfer_r <= xfer_nxt; fin_r <= fin_nxt; ptr_r <= ptr_nxt; ind_r <= ind_nxt;
        ibank_r <= ibank_nxt; latch_r <= latch_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hdma_pkg::REG_PARAMS:   params_r <= cfg_data[7:0];
          hdma_pkg::REG_B_ADDR:   b_addr_r <= cfg_data[7:0];
          hdma_pkg::REG_A_ADDR: begin
            a_addr_r <= cfg_data;
            work_r <= cfg_data;
          end
          hdma_pkg::REG_A_BANK:   a_bank_r <= cfg_data[7:0];
          hdma_pkg::REG_COUNT:    count_r <= cfg_data;
          hdma_pkg::REG_IND_BANK: ind_bank_r <= cfg_data[7:0];
          hdma_pkg::REG_HDMA_EN:  hdma_en_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign out_bus_op        = buf_r[0].bus_op;
  assign out_address       = buf_r[0].address;
  assign out_data          = buf_r[0].data;
  assign out_master_clocks = buf_r[0].master_clocks;
  assign out_last          = buf_r[0].last;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd3)
    else $error("output buffer overflow");
  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= 2'd2 |-> !in_fire)
    else $error("input taken with full buffer");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && nres != 2'd0 && r0.last && nres == 2'd1) |=> phase_r == hdma_pkg::PH_IDLE)
    else $error("final result without idle phase");

endmodule
